### sv/aes256_ctr_keystream_xor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the AES-256 CTR keystream XOR block.
// ----------------------------------------------------------------------------
`ifndef AES256_CTR_KEYSTREAM_XOR_ASSERT_SVH
`define AES256_CTR_KEYSTREAM_XOR_ASSERT_SVH

// Property that holds on every clock edge outside reset.
`define ACX_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked during reset as well.
`define ACX_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/acx_pkg.sv
// ----------------------------------------------------------------------------
// acx_pkg
// Types, constants and AES functions for the AES-256 CTR keystream XOR block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acx_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned PosW       = 4;
  localparam int unsigned NumKeyRegs = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned NumRounds  = 14;
  localparam int unsigned RoundW     = 4;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    ACT_DATA = 1'b0,
    ACT_LOAD = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_WORD0 = 2'd0,
    REG_KEY_WORD1 = 2'd1,
    REG_KEY_WORD2 = 2'd2,
    REG_KEY_WORD3 = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic        action;
    logic [7:0]  data_byte;
    logic        last_of_call;
    logic [63:0] counter_high;
    logic [63:0] counter_low;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        call_done;
    logic [63:0] next_counter_high;
    logic [63:0] next_counter_low;
  } out_word_t;

  // Classified data byte passed from front to back.
  typedef struct packed {
    logic         new_block;
    logic [127:0] ctr;
    logic [127:0] next_ctr;
    logic [PosW-1:0] pos;
    logic [7:0]   data_byte;
    logic         last;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // State byte i is bits [127-8i -: 8], column-major as in FIPS-197.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = sbox(s[127-8*(r+4*((c+r)%4)) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] t);
    logic [127:0] s;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = t[127-32*c -: 8];
      a1 = t[119-32*c -: 8];
      a2 = t[111-32*c -: 8];
      a3 = t[103-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      s[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      s[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      s[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      s[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return s;
  endfunction

  // Next eight key words from the previous eight (one 256-bit step).
  function automatic logic [255:0] key_step(input logic [255:0] k, input logic [7:0] rc);
    logic [31:0] w [8];
    logic [31:0] t;
    for (int i = 0; i < 8; i++) w[i] = k[255-32*i -: 32];
    t = sub_word({w[7][23:0], w[7][31:24]}) ^ {rc, 24'h0};
    w[0] = w[0] ^ t;
    for (int i = 1; i < 4; i++) w[i] = w[i] ^ w[i-1];
    w[4] = w[4] ^ sub_word(w[3]);
    for (int i = 5; i < 8; i++) w[i] = w[i] ^ w[i-1];
    return {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]};
  endfunction

endpackage

### sv/aes256_ctr_keystream_xor.sv
// ----------------------------------------------------------------------------
// aes256_ctr_keystream_xor
// AES-256 counter-mode keystream XOR, one byte word per handshake.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_stall_o  | acx_pkg::in_word_t
// out     | output    | out_valid_o/out_stall_i| acx_pkg::out_word_t
// cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
// A data byte within a block uses the stored keystream; the first byte of each
// block waits for the iterative round unit (one AES round per cycle). Loads
// produce no word. A two-entry queue separates the counter front end from
// the cipher, so input and output stall on their own.
// Reset is asynchronous and clears the counter, position, key and queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes256_ctr_keystream_xor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [acx_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [63:0]                        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  acx_pkg::in_word_t                  in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output acx_pkg::out_word_t                 out_word_o
);

  logic [63:0]   key_q [acx_pkg::NumKeyRegs];
  logic          job_valid, job_take;
  acx_pkg::job_t job;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < acx_pkg::NumKeyRegs; i++) key_q[i] <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  acx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .job_valid_o (job_valid),
    .job_take_i  (job_take),
    .job_o       (job)
  );

  acx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .job_valid_i (job_valid),
    .job_take_o  (job_take),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

### sv/acx_front.sv
// ----------------------------------------------------------------------------
// acx_front
// Accepts words, handles counter loads and byte position, and queues one job
// per data byte for the cipher back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acx_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  acx_pkg::in_word_t  in_word_i,
  output logic               job_valid_o,
  input  logic               job_take_i,
  output acx_pkg::job_t      job_o
);

  logic [127:0]             ctr_q, ctr_d;
  logic [acx_pkg::PosW-1:0] pos_q, pos_d;
  acx_pkg::job_t            q_mem [acx_pkg::QueueDepth];
  logic                     wr_q, rd_q;
  logic [1:0]               cnt_q;
  logic                     accept, push, pop, wrap;
  logic [127:0]             inc;

  assign in_stall_o = (cnt_q == 2'(acx_pkg::QueueDepth));
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && (in_word_i.action == acx_pkg::ACT_DATA);
  assign pop        = job_valid_o && job_take_i;
  assign inc        = ctr_q + 128'd1;
  assign wrap       = in_word_i.last_of_call || (pos_q == '1);

  // Counter and byte position bookkeeping.
  always_comb begin
    ctr_d = ctr_q;
    pos_d = pos_q;
    if (accept) begin
      if (in_word_i.action == acx_pkg::ACT_LOAD) begin
        ctr_d = {in_word_i.counter_high, in_word_i.counter_low};
        pos_d = '0;
      end else if (wrap) begin
        ctr_d = inc;
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
      pos_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      ctr_q <= ctr_d;
      pos_q <= pos_d;
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Two-entry job queue.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= '{new_block: (pos_q == '0), ctr: ctr_q, next_ctr: inc,
                       pos: pos_q, data_byte: in_word_i.data_byte,
                       last: in_word_i.last_of_call};
    end
  end

  assign job_valid_o = (cnt_q != '0);
  assign job_o       = q_mem[rd_q];

endmodule

### sv/acx_back.sv
// ----------------------------------------------------------------------------
// acx_back
// Computes AES-256 of the counter one round per cycle with on-the-fly key
// expansion and XORs each data byte with its keystream byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acx_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [255:0]        key_i,
  input  logic                job_valid_i,
  output logic                job_take_o,
  input  acx_pkg::job_t       job_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output acx_pkg::out_word_t  out_word_o
);

  logic                       busy_q;
  logic                       done_q;
  logic [acx_pkg::RoundW-1:0] rnd_q;
  logic [127:0]               st_q, ks_q;
  logic [255:0]               rk_q;
  logic [7:0]                 rc_q;
  logic                       out_valid_q;
  acx_pkg::out_word_t         out_q;
  logic                       out_free, start, emit;
  logic [127:0]               ss, st_next;
  logic [255:0]               rk_next;
  logic [7:0]                 ks_byte;

  // A first byte of a block starts the round unit once, then waits for done_q.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign start      = job_valid_i && job_i.new_block && !busy_q && !done_q;
  assign emit       = job_valid_i && (!job_i.new_block || done_q) && !busy_q && out_free;
  assign job_take_o = emit;

  // One round: odd rounds use the lower key half, even rounds the upper,
  // and the key schedule steps after every odd round.
  always_comb begin
    ss      = acx_pkg::sub_shift(st_q);
    st_next = (rnd_q == 4'(acx_pkg::NumRounds)) ? ss : acx_pkg::mix_columns(ss);
    st_next = st_next ^ (rnd_q[0] ? rk_q[127:0] : rk_q[255:128]);
    rk_next = rnd_q[0] ? acx_pkg::key_step(rk_q, rc_q) : rk_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (start) begin
        busy_q <= 1'b1;
        rnd_q  <= 4'd1;
      end else if (busy_q) begin
        if (rnd_q == 4'(acx_pkg::NumRounds)) busy_q <= 1'b0;
        rnd_q <= rnd_q + 1'b1;
      end
      if (emit) done_q <= 1'b0;
      else if (busy_q && (rnd_q == 4'(acx_pkg::NumRounds))) done_q <= 1'b1;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Round datapath; the finished block stays in ks_q for the rest of its bytes.
  always_ff @(posedge clk_i) begin
    if (start) begin
      st_q <= job_i.ctr ^ key_i[255:128];
      rk_q <= key_i;
      rc_q <= 8'h01;
    end else if (busy_q) begin
      st_q <= st_next;
      rk_q <= rk_next;
      if (rnd_q[0]) rc_q <= acx_pkg::xtime(rc_q);
      if (rnd_q == 4'(acx_pkg::NumRounds)) ks_q <= st_next;
    end
  end

  // The round key for round 1 is the lower half of the loaded key.
  // (st_q at round 1 uses rk_q[127:0] since rnd_q[0] is one.)

  assign ks_byte = ks_q[127 - 8*job_i.pos -: 8];

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte          <= job_i.data_byte ^ ks_byte;
      out_q.call_done         <= job_i.last;
      out_q.next_counter_high <= job_i.last ? job_i.next_ctr[127:64] : 64'd0;
      out_q.next_counter_low  <= job_i.last ? job_i.next_ctr[63:0] : 64'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### sv/acx_checker.sv
// ----------------------------------------------------------------------------
// acx_checker
// Port-level checks for the AES-256 CTR keystream XOR block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aes256_ctr_keystream_xor_assert.svh"

module acx_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input acx_pkg::out_word_t out_word_o
);

  // Nothing leaves the block in reset.
  `ACX_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o, "output valid in reset")
  // A stalled output word holds.
  `ACX_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o), "stalled word changed")
  // Counter fields are zero unless the call is done.
  `ACX_ASSERT(a_ctr_zero, clk_i, rst_ni, out_valid_o && !out_word_o.call_done |-> out_word_o.next_counter_high == 64'd0 && out_word_o.next_counter_low == 64'd0, "counter not zero")
  // Input is never stalled right after reset.
  `ACX_ASSERT(a_in_open, clk_i, rst_ni, $rose(rst_ni) |-> !in_stall_o, "input stalled after reset")

endmodule

bind aes256_ctr_keystream_xor acx_checker u_acx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
